### hw/rtl/dse_pkg.sv
// Shared constants, register indexes and the value scaling function of the DMX slot extractor.
package dse_pkg;

    localparam int COUNT_W    = 10;
    localparam int INDEX_W    = 4;
    localparam int BYTE_W     = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [INDEX_W-1:0] NUM_PARAMS = 4'd10;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_DMX_ENABLE    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_ADDRESS = 1'b1;

    // Parameter indexes that carry a scaled value
    localparam logic [INDEX_W-1:0] PARAM_RELEASE   = 4'd6;
    localparam logic [INDEX_W-1:0] PARAM_ANIMATION = 4'd7;
    localparam logic [INDEX_W-1:0] PARAM_TRIGGER   = 4'd8;
    localparam logic [INDEX_W-1:0] PARAM_CURVE     = 4'd9;

    localparam logic [6:0] K_RELEASE   = 7'd100;
    localparam logic [6:0] K_ANIMATION = 7'd8;
    localparam logic [6:0] K_TRIGGER   = 7'd6;
    localparam logic [6:0] K_CURVE     = 7'd3;

    // Raw byte for the colour slots, floor(byte * K / 255) for the others.
    // x / 255 is exact as (x + (x >> 8) + 1) >> 8 for x below 65535.
    function automatic logic [BYTE_W-1:0] scale_value(input logic [INDEX_W-1:0] idx,
                                                      input logic [BYTE_W-1:0]  b);
        logic [6:0]  k;
        logic        raw;
        logic [14:0] prod;
        logic [15:0] sum;
        k   = '0;
        raw = 1'b0;
        case (idx)
            PARAM_RELEASE:   k = K_RELEASE;
            PARAM_ANIMATION: k = K_ANIMATION;
            PARAM_TRIGGER:   k = K_TRIGGER;
            PARAM_CURVE:     k = K_CURVE;
            default:         raw = 1'b1;
        endcase
        prod = 15'(b) * 15'(k);
        sum  = 16'(prod) + 16'(prod[14:8]) + 16'd1;
        return raw ? b : sum[15:8];
    endfunction

endpackage

### hw/rtl/dmx_slot_extractor.sv
// DMX slot extractor: slot counter, address match and parameter scaling for one fixture.
// Each input item is one received byte (tdata) with its framing-error flag (tuser). A break
// clears the slot counter, any other byte advances it and it saturates at 1023. The start
// code is count 1, so DMX slot s is count s + 1; counts start_address + 1 through
// start_address + 10 each give one output item with the parameter index (tuser) and value
// (tdata). Parameters 0-5 carry the raw byte, 6-9 carry floor(byte * K / 255) with K = 100,
// 8, 6 and 3. While dmx_enable is 0, items are taken and dropped and the counter holds.
// Throughput is one item per clock while the output is not stalled; an item passes an input
// register and then an output register, which offers its result on the output.
// While a result waits, the input takes an item only into an empty input register.
module dmx_slot_extractor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dse_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [dse_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [7:0] rx_byte
    input  logic                             s_axis_tuser,   // [0] frame_error
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // [7:0] param_value
    output logic [dse_pkg::INDEX_W-1:0]      m_axis_tuser    // [3:0] param_index
);

    logic                              r_dmx_enable;
    logic [dse_pkg::COUNT_W-1:0]       r_start_address;
    logic [dse_pkg::COUNT_W-1:0]       r_slot_count;
    logic [dse_pkg::COUNT_W-1:0]       n_slot_count;

    logic                              r_in_valid;
    logic [dse_pkg::BYTE_W-1:0]        r_in_byte;
    logic                              r_in_ferr;

    logic                              r_out_valid;
    logic [dse_pkg::INDEX_W-1:0]       r_out_index;
    logic [dse_pkg::BYTE_W-1:0]        r_out_value;

    logic                              advance;
    logic                              in_accept;
    logic [dse_pkg::COUNT_W-1:0]       offset;
    logic                              hit;
    logic [dse_pkg::INDEX_W-1:0]       hit_index;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_slot_count = r_slot_count;
        if (r_dmx_enable) begin
            if (r_in_ferr) begin
                n_slot_count = '0;
            end else if (r_slot_count != dse_pkg::COUNT_MAX) begin
                n_slot_count = r_slot_count + dse_pkg::COUNT_W'(1);
            end
        end
    end

    // Match when start_address < count and count - start_address - 1 < NUM_PARAMS
    assign offset    = n_slot_count - r_start_address - dse_pkg::COUNT_W'(1);
    assign hit       = (n_slot_count > r_start_address)
                       && (offset < dse_pkg::COUNT_W'(dse_pkg::NUM_PARAMS));
    assign hit_index = offset[dse_pkg::INDEX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmx_enable    <= 1'b0;
            r_start_address <= dse_pkg::COUNT_W'(1);
            r_slot_count    <= '0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    dse_pkg::CFG_DMX_ENABLE:    r_dmx_enable    <= i_cfg_wdata[0];
                    dse_pkg::CFG_START_ADDRESS: r_start_address <= i_cfg_wdata;
                    default: ;
                endcase
            end
            // fill an empty input register even while the output stalls
            if (s_axis_tready) begin
                r_in_valid <= in_accept;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && r_dmx_enable && hit;
                if (r_in_valid) begin
                    r_slot_count <= n_slot_count;
                end
            end
        end
        // payload, no reset
        if (in_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_ferr <= s_axis_tuser;
        end
        if (advance && r_in_valid) begin
            r_out_index <= hit_index;
            r_out_value <= dse_pkg::scale_value(hit_index, r_in_byte);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_index;

`ifndef SYNTHESIS
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_index < dse_pkg::NUM_PARAMS))
        else $error("output parameter index out of range");

    a_disabled_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dmx_enable |-> (n_slot_count == r_slot_count))
        else $error("slot counter moves while disabled");

    a_break_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && r_in_ferr && r_dmx_enable) |=> (r_slot_count == '0))
        else $error("break did not clear the slot counter");
`endif

endmodule
